// ===== rtl/icv_pkg.sv =====
// shared types and constants for the 2-d image convolution block
package icv_pkg;

  localparam int PIX_W       = 16;
  localparam int COEF_W      = 12;
  localparam int PROD_W      = PIX_W + COEF_W;
  localparam int SUM_W       = 32;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 12;
  localparam int RAD_W       = 2;
  localparam int IMG_W_W     = 11;
  localparam int IMG_H_W     = 12;
  localparam int NUM_KROWS   = 5;
  localparam int KROW_W      = 60;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_RADIUS,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_KERNEL_ROW0,
    REG_KERNEL_ROW1,
    REG_KERNEL_ROW2,
    REG_KERNEL_ROW3,
    REG_KERNEL_ROW4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel;
    logic                    first_of_frame;
  } pix_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_value;
    logic [COL_W-1:0]        centre_column;
    logic [ROW_W-1:0]        centre_row;
    logic                    last_of_frame;
  } conv_rsp_t;

  typedef struct packed {
    logic [COL_W-1:0] centre_column;
    logic [ROW_W-1:0] centre_row;
    logic             last_of_frame;
  } job_meta_t;

  typedef logic [NUM_KROWS-1:0][KROW_W-1:0] kernel_t;

endpackage

// ===== rtl/image_convolution_2d.sv =====
// top level of the streaming 2-d image convolution block
// pixels arrive one per request on the in channel (valid/ready) in raster
// order; first_of_frame restarts the column and row counters. a result
// request leaves on the out channel for every position whose whole window
// lies inside the image, labelled with the centre column and row, and
// last_of_frame set on the final pixel of the frame. border positions are
// not emitted.
// throughput is one pixel per clock while in_ready_o stays high; an
// accepted pixel passes the front stage into the job queue, one product
// stage and two adder stages. the line store is one memory of MAX_WIDTH words,
// read and written once per pixel at the current column.
// the configuration port takes a register write on any edge with
// cfg_we_i high; writes belong between frames while the block is idle.
// reset clears the counters and pipeline valids and loads radius 1,
// width 640, height 480 and zero coefficients; line store and window
// hold stale data until written. when out_ready_i is low the back end
// holds, the job queue fills and in_ready_o drops.
module image_convolution_2d #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  icv_pkg::pix_req_t                 in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output icv_pkg::conv_rsp_t                out_rsp_o,
  input  logic                              cfg_we_i,
  input  logic [icv_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [icv_pkg::KROW_W-1:0]        cfg_data_i
);

  localparam int PIX_W   = icv_pkg::PIX_W;
  localparam int RAD_W   = icv_pkg::RAD_W;
  localparam int IMG_W_W = icv_pkg::IMG_W_W;
  localparam int IMG_H_W = icv_pkg::IMG_H_W;
  localparam int QDEPTH  = icv_pkg::QUEUE_DEPTH;
  localparam int SIDE    = 2*MAX_RADIUS + 1;
  localparam int WIN_W   = SIDE*SIDE*PIX_W;
  localparam int META_W  = $bits(icv_pkg::job_meta_t);
  localparam int JOB_W   = WIN_W + META_W;
  localparam int CW      = $clog2(QDEPTH+1);
  localparam int WCMP_W  = (IMG_W_W > $clog2(MAX_WIDTH+1) ? IMG_W_W
                                                          : $clog2(MAX_WIDTH+1)) + 1;

  logic [RAD_W-1:0]    radius_q;
  logic [IMG_W_W-1:0]  width_q;
  logic [IMG_H_W-1:0]  height_q;
  icv_pkg::kernel_t    kernel_q;

  logic [RAD_W-1:0]    rad_sat;
  logic [IMG_W_W-1:0]  width_sat;
  logic [IMG_H_W-1:0]  height_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RAD_W'(1);
      width_q  <= IMG_W_W'(640);
      height_q <= IMG_H_W'(480);
      kernel_q <= '0;
    end else if (cfg_we_i) begin
      unique case (icv_pkg::cfg_reg_e'(cfg_index_i))
        icv_pkg::REG_KERNEL_RADIUS: radius_q    <= cfg_data_i[RAD_W-1:0];
        icv_pkg::REG_IMAGE_WIDTH:   width_q     <= cfg_data_i[IMG_W_W-1:0];
        icv_pkg::REG_IMAGE_HEIGHT:  height_q    <= cfg_data_i[IMG_H_W-1:0];
        icv_pkg::REG_KERNEL_ROW0:   kernel_q[0] <= cfg_data_i;
        icv_pkg::REG_KERNEL_ROW1:   kernel_q[1] <= cfg_data_i;
        icv_pkg::REG_KERNEL_ROW2:   kernel_q[2] <= cfg_data_i;
        icv_pkg::REG_KERNEL_ROW3:   kernel_q[3] <= cfg_data_i;
        icv_pkg::REG_KERNEL_ROW4:   kernel_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp register values into the supported range
  always_comb begin
    rad_sat = (radius_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_q;
    if (width_q == '0) begin
      width_sat = IMG_W_W'(1);
    end else if (WCMP_W'(width_q) > WCMP_W'(MAX_WIDTH)) begin
      width_sat = IMG_W_W'(MAX_WIDTH);
    end else begin
      width_sat = width_q;
    end
    height_sat = (height_q == '0) ? IMG_H_W'(1) : height_q;
  end

  logic                 push;
  logic [WIN_W-1:0]     push_win;
  icv_pkg::job_meta_t   push_meta;
  logic [JOB_W-1:0]     pop_data;
  logic                 q_not_empty;
  logic                 q_pop;
  logic [CW-1:0]        q_count;
  icv_pkg::job_meta_t   pop_meta;

  icv_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS),
    .QDEPTH     (QDEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .rad_i       (rad_sat),
    .width_i     (width_sat),
    .height_i    (height_sat),
    .q_count_i   (q_count),
    .push_o      (push),
    .push_win_o  (push_win),
    .push_meta_o (push_meta)
  );

  icv_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_meta, push_win}),
    .pop_i       (q_pop),
    .pop_data_o  (pop_data),
    .not_empty_o (q_not_empty),
    .count_o     (q_count)
  );

  assign pop_meta = pop_data[JOB_W-1:WIN_W];

  icv_back #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_not_empty),
    .q_pop_o     (q_pop),
    .q_win_i     (pop_data[WIN_W-1:0]),
    .q_meta_i    (pop_meta),
    .rad_i       (rad_sat),
    .kernel_i    (kernel_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ===== rtl/icv_fifo.sv =====
// small job queue between the window front end and the multiply-add back end
module icv_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             push_data_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             pop_data_o,
  output logic                         not_empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o  = mem_q[rd_ptr_q];
  assign not_empty_o = (count_q != '0);
  assign count_o     = count_q;

endmodule

// ===== rtl/icv_front.sv =====
// front end: position counters, line store, sliding window and emit decision
module icv_front #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_RADIUS  = 2,
  parameter int QDEPTH      = 4
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  icv_pkg::pix_req_t                         in_req_i,
  input  logic [icv_pkg::RAD_W-1:0]                 rad_i,
  input  logic [icv_pkg::IMG_W_W-1:0]               width_i,
  input  logic [icv_pkg::IMG_H_W-1:0]               height_i,
  input  logic [$clog2(QDEPTH+1)-1:0]               q_count_i,
  output logic                                      push_o,
  output logic [(2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)*icv_pkg::PIX_W-1:0] push_win_o,
  output icv_pkg::job_meta_t                        push_meta_o
);

  localparam int PIX_W   = icv_pkg::PIX_W;
  localparam int COL_W   = icv_pkg::COL_W;
  localparam int ROW_W   = icv_pkg::ROW_W;
  localparam int IMG_W_W = icv_pkg::IMG_W_W;
  localparam int IMG_H_W = icv_pkg::IMG_H_W;
  localparam int SIDE    = 2*MAX_RADIUS + 1;
  localparam int NROWS   = 2*MAX_RADIUS;
  localparam int AW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW      = $clog2(QDEPTH+1);
  localparam int CMP_W   = (COL_W > $clog2(MAX_WIDTH+1) ? COL_W : $clog2(MAX_WIDTH+1)) + 1;

  logic                      accept;
  logic [COL_W-1:0]          col_q, col_d, cur_col;
  logic [ROW_W-1:0]          row_q, row_d, cur_row;
  logic [IMG_W_W-1:0]        col_ext;
  logic [2:0]                span;
  logic                      emit_new;
  logic                      in_mem_new;
  logic [AW-1:0]             addr_new;
  icv_pkg::job_meta_t        meta_new;

  // stage b: item whose line store read is back
  logic                      b_v_q;
  logic                      b_emit_q;
  logic                      b_in_mem_q;
  logic [AW-1:0]             b_addr_q;
  logic signed [PIX_W-1:0]   b_pix_q;
  icv_pkg::job_meta_t        b_meta_q;

  logic [NROWS-1:0][PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [NROWS-1:0][PIX_W-1:0] rd_q;
  logic [NROWS-1:0][PIX_W-1:0] wr_data;
  logic                        wr_en;
  logic                        bypass;

  logic [SIDE-1:0][PIX_W-1:0]            col_px;
  logic [SIDE-1:0][SIDE-1:0][PIX_W-1:0]  win_q, win_d;

  logic                      b_push;

  assign b_push     = b_v_q && b_emit_q;
  // room for the item in stage b and for one more
  assign in_ready_o = ({1'b0, q_count_i} + {{CW{1'b0}}, b_push}) < (CW+1)'(QDEPTH);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cur_col  = in_req_i.first_of_frame ? '0 : col_q;
    cur_row  = in_req_i.first_of_frame ? '0 : row_q;
    col_ext  = IMG_W_W'(cur_col);
    span     = {1'b0, rad_i} << 1;
    emit_new = (col_ext < width_i) && (cur_row < height_i) &&
               (cur_col >= COL_W'(span)) && (cur_row >= ROW_W'(span));
    meta_new.centre_column = cur_col - COL_W'(rad_i);
    meta_new.centre_row    = cur_row - ROW_W'(rad_i);
    meta_new.last_of_frame = (col_ext == width_i - IMG_W_W'(1)) &&
                             (cur_row == height_i - IMG_H_W'(1));
    in_mem_new = CMP_W'(cur_col) < CMP_W'(MAX_WIDTH);
    addr_new   = AW'(cur_col);
    if (col_ext >= width_i - IMG_W_W'(1)) begin
      col_d = '0;
      row_d = (cur_row >= height_i - IMG_H_W'(1)) ? '0 : cur_row + ROW_W'(1);
    end else begin
      col_d = cur_col + COL_W'(1);
      row_d = cur_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      b_v_q <= 1'b0;
    end else begin
      b_v_q <= accept;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_emit_q   <= emit_new;
      b_in_mem_q <= in_mem_new;
      b_addr_q   <= addr_new;
      b_pix_q    <= in_req_i.pixel;
      b_meta_q   <= meta_new;
    end
  end

  // vertical column: stored rows oldest first, then the new pixel
  always_comb begin
    for (int i = 0; i < NROWS; i++) begin
      col_px[i] = b_in_mem_q ? rd_q[i] : '0;
    end
    col_px[SIDE-1] = b_pix_q;
    for (int i = 0; i < NROWS; i++) begin
      wr_data[i] = col_px[i+1];
    end
  end

  assign wr_en  = b_v_q && b_in_mem_q;
  // same column written back while being read again
  assign bypass = wr_en && (b_addr_q == addr_new);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[b_addr_q] <= wr_data;
    end
    if (accept) begin
      if (bypass) begin
        rd_q <= wr_data;
      end else begin
        rd_q <= line_mem[addr_new];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SIDE; i++) begin
      for (int j = 0; j < SIDE - 1; j++) begin
        win_d[i][j] = win_q[i][j+1];
      end
      win_d[i][SIDE-1] = col_px[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_v_q) begin
      win_q <= win_d;
    end
  end

  assign push_o      = b_push;
  assign push_win_o  = win_d;
  assign push_meta_o = b_meta_q;

endmodule

// ===== rtl/icv_back.sv =====
// back end: parallel window products, registered adder tree and output register
module icv_back #(
  parameter int MAX_RADIUS = 2
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      q_valid_i,
  output logic                                      q_pop_o,
  input  logic [(2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)*icv_pkg::PIX_W-1:0] q_win_i,
  input  icv_pkg::job_meta_t                        q_meta_i,
  input  logic [icv_pkg::RAD_W-1:0]                 rad_i,
  input  icv_pkg::kernel_t                          kernel_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output icv_pkg::conv_rsp_t                        out_rsp_o
);

  localparam int PIX_W  = icv_pkg::PIX_W;
  localparam int COEF_W = icv_pkg::COEF_W;
  localparam int PROD_W = icv_pkg::PROD_W;
  localparam int SUM_W  = icv_pkg::SUM_W;
  localparam int SIDE   = 2*MAX_RADIUS + 1;

  logic [SIDE-1:0][SIDE-1:0][PIX_W-1:0] win;
  logic signed [COEF_W-1:0]  coef [SIDE][SIDE];
  logic [2:0]                base;

  logic                      adv;
  logic                      s1_v_q, s2_v_q, s3_v_q;
  icv_pkg::job_meta_t        s1_meta_q, s2_meta_q, s3_meta_q;
  logic signed [PROD_W-1:0]  prod_q [SIDE][SIDE];
  logic signed [SUM_W-1:0]   row_sum_d [SIDE];
  logic signed [SUM_W-1:0]   row_sum_q [SIDE];
  logic signed [SUM_W-1:0]   total_d, total_q;

  assign win  = q_win_i;
  // window rows and columns below base lie outside the kernel
  assign base = 3'(SIDE - 1) - ({1'b0, rad_i} << 1);

  always_comb begin
    logic [2:0] yk;
    logic [2:0] xk;
    for (int wr = 0; wr < SIDE; wr++) begin
      for (int wc = 0; wc < SIDE; wc++) begin
        yk = 3'(wr) - base;
        xk = 3'(wc) - base;
        if ((3'(wr) >= base) && (3'(wc) >= base)) begin
          coef[wr][wc] = kernel_i[yk][xk*COEF_W +: COEF_W];
        end else begin
          coef[wr][wc] = '0;
        end
      end
    end
  end

  assign adv      = !s3_v_q || out_ready_i;
  assign q_pop_o  = adv && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= q_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_comb begin
    for (int i = 0; i < SIDE; i++) begin
      row_sum_d[i] = '0;
      for (int j = 0; j < SIDE; j++) begin
        row_sum_d[i] = row_sum_d[i] + SUM_W'(prod_q[i][j]);
      end
    end
    total_d = '0;
    for (int i = 0; i < SIDE; i++) begin
      total_d = total_d + row_sum_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < SIDE; i++) begin
        for (int j = 0; j < SIDE; j++) begin
          prod_q[i][j] <= $signed(win[i][j]) * coef[i][j];
        end
        row_sum_q[i] <= row_sum_d[i];
      end
      total_q   <= total_d;
      s1_meta_q <= q_meta_i;
      s2_meta_q <= s1_meta_q;
      s3_meta_q <= s2_meta_q;
    end
  end

  assign out_valid_o             = s3_v_q;
  assign out_rsp_o.sum_value     = total_q;
  assign out_rsp_o.centre_column = s3_meta_q.centre_column;
  assign out_rsp_o.centre_row    = s3_meta_q.centre_row;
  assign out_rsp_o.last_of_frame = s3_meta_q.last_of_frame;

endmodule

// ===== tb/sv/image_convolution_2d_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the streaming 2-d image convolution block
module image_convolution_2d_tb;

  localparam int PIX_W          = icv_pkg::PIX_W;
  localparam int COEF_W         = icv_pkg::COEF_W;
  localparam int SUM_W          = icv_pkg::SUM_W;
  localparam int COL_W          = icv_pkg::COL_W;
  localparam int ROW_W          = icv_pkg::ROW_W;
  localparam int RAD_W          = icv_pkg::RAD_W;
  localparam int IMG_W_W        = icv_pkg::IMG_W_W;
  localparam int IMG_H_W        = icv_pkg::IMG_H_W;
  localparam int NUM_KROWS      = icv_pkg::NUM_KROWS;
  localparam int KROW_W         = icv_pkg::KROW_W;
  localparam int CFG_IDX_W      = icv_pkg::CFG_IDX_W;

  localparam int MAX_W          = 1024;
  localparam int MAX_R          = 2;
  localparam int FIRST_W        = 64;
  localparam int RANDOM_ITEMS   = 1650;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_AT        = 200;
  localparam int HOLD_CYCLES    = 500;
  localparam int REPORT_LIMIT   = 10;
  localparam int CYCLE_LIMIT    = 1000000;

  class window_sum_board;
    logic [RAD_W-1:0]          radius_reg;
    logic [IMG_W_W-1:0]        width_reg;
    logic [IMG_H_W-1:0]        height_reg;
    logic [KROW_W-1:0]         kernel_rows [NUM_KROWS];
    logic signed [PIX_W-1:0]   line_mem [2*MAX_R][MAX_W];
    logic signed [PIX_W-1:0]   win [2*MAX_R+1][2*MAX_R+1];
    logic [COL_W-1:0]          col_cnt;
    logic [ROW_W-1:0]          row_cnt;
    icv_pkg::conv_rsp_t        expected_sums [$];
    int                        errors;
    int                        results_seen;

    function new();
      radius_reg   = 1;
      width_reg    = 640;
      height_reg   = 480;
      foreach (kernel_rows[i]) kernel_rows[i] = '0;
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      col_cnt      = '0;
      row_cnt      = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void note_config(icv_pkg::cfg_reg_e idx, logic [KROW_W-1:0] data);
      case (idx)
        icv_pkg::REG_KERNEL_RADIUS: radius_reg = data[RAD_W-1:0];
        icv_pkg::REG_IMAGE_WIDTH:   width_reg  = data[IMG_W_W-1:0];
        icv_pkg::REG_IMAGE_HEIGHT:  height_reg = data[IMG_H_W-1:0];
        default:                    kernel_rows[idx - icv_pkg::REG_KERNEL_ROW0] = data;
      endcase
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction

    // shift the new pixel into the line store and window, then emit the
    // window sum when the window lies wholly inside the image
    function void predict_window_sum(icv_pkg::pix_req_t req);
      logic signed [PIX_W-1:0] column [2*MAX_R+1];
      int                 rad, w, h, c, r, span, base, i, j;
      longint             acc;
      icv_pkg::conv_rsp_t rsp;
      rad = (radius_reg > MAX_R) ? MAX_R : int'(radius_reg);
      w   = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : int'(width_reg));
      h   = (height_reg == 0) ? 1 : int'(height_reg);
      if (req.first_of_frame) begin
        col_cnt = '0;
        row_cnt = '0;
      end
      c = col_cnt;
      r = row_cnt;
      for (i = 0; i < 2*MAX_R; i++) column[i] = line_mem[i][c];
      column[2*MAX_R] = req.pixel;
      for (i = 0; i < 2*MAX_R; i++) line_mem[i][c] = column[i+1];
      for (i = 0; i <= 2*MAX_R; i++) begin
        for (j = 0; j < 2*MAX_R; j++) win[i][j] = win[i][j+1];
        win[i][2*MAX_R] = column[i];
      end
      span = 2 * rad;
      if (c < w && r < h && c >= span && r >= span) begin
        acc  = 0;
        base = 2*MAX_R - span;
        for (i = 0; i <= span; i++) begin
          for (j = 0; j <= span; j++) begin
            acc += longint'(win[base+i][base+j]) *
                   longint'($signed(kernel_rows[i][COEF_W*j +: COEF_W]));
          end
        end
        rsp.sum_value     = acc[SUM_W-1:0];
        rsp.centre_column = COL_W'(c - rad);
        rsp.centre_row    = ROW_W'(r - rad);
        rsp.last_of_frame = (c == w - 1) && (r == h - 1);
        expected_sums.push_back(rsp);
      end
      if (c >= w - 1) begin
        col_cnt = '0;
        row_cnt = (r >= h - 1) ? '0 : ROW_W'(r + 1);
      end else begin
        col_cnt = COL_W'(c + 1);
      end
    endfunction

    function void check_window_sum(icv_pkg::conv_rsp_t got);
      icv_pkg::conv_rsp_t want;
      results_seen++;
      if (expected_sums.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result: sum %0d col %0d row %0d last %0b", got.sum_value,
                   got.centre_column, got.centre_row, got.last_of_frame);
        return;
      end
      want = expected_sums.pop_front();
      if (got.sum_value !== want.sum_value || got.centre_column !== want.centre_column ||
          got.centre_row !== want.centre_row || got.last_of_frame !== want.last_of_frame) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display({"mismatch: exp sum %0d col %0d row %0d last %0b",
                    " / got sum %0d col %0d row %0d last %0b"},
                   want.sum_value, want.centre_column, want.centre_row, want.last_of_frame,
                   got.sum_value, got.centre_column, got.centre_row, got.last_of_frame);
      end
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  icv_pkg::pix_req_t     in_req_i    = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  icv_pkg::conv_rsp_t    out_rsp_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [KROW_W-1:0]     cfg_data_i  = '0;

  window_sum_board       board;
  logic [KROW_W-1:0]     reg_val [8];
  bit                    in_gaps_on  = 1'b1;
  bit                    out_gaps_on = 1'b1;
  int                    items_sent  = 0;
  int                    out_hold    = 3;
  bit                    hold_done   = 1'b0;
  int                    cycle_count = 0;

  image_convolution_2d #(
    .MAX_WIDTH  (MAX_W),
    .MAX_RADIUS (MAX_R)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        board.check_window_sum(out_rsp_o);
        if (!hold_done && board.results_seen == HOLD_AT) begin
          hold_done = 1'b1;
          out_hold  = HOLD_CYCLES;
        end else begin
          out_hold = out_gaps_on ? $urandom_range(0, 14) : 0;
        end
        out_ready_i <= (out_hold == 0);
      end else if (!out_ready_i) begin
        if (out_hold <= 1) out_ready_i <= 1'b1;
        out_hold = out_hold - 1;
      end
    end
  end

  function automatic logic signed [PIX_W-1:0] draw_pixel();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'shffff;
      default: return PIX_W'($urandom());
    endcase
  endfunction

  function automatic logic [KROW_W-1:0] draw_kernel_row();
    logic [KROW_W-1:0] row;
    int k;
    for (k = 0; k < 5; k++) begin
      case ($urandom_range(0, 7))
        0:       row[COEF_W*k +: COEF_W] = 12'h800;
        1:       row[COEF_W*k +: COEF_W] = 12'h7ff;
        2:       row[COEF_W*k +: COEF_W] = 12'h000;
        default: row[COEF_W*k +: COEF_W] = COEF_W'($urandom());
      endcase
    end
    return row;
  endfunction

  task automatic program_regs(input logic [7:0] mask);
    int i;
    for (i = 0; i < 8; i++) begin
      if (mask[i]) begin
        cfg_we_i    <= 1'b1;
        cfg_index_i <= icv_pkg::cfg_reg_e'(i);
        cfg_data_i  <= reg_val[i];
        @(posedge clk_i);
        board.note_config(icv_pkg::cfg_reg_e'(i), reg_val[i]);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  // valid is only lowered when a gap is drawn, so back-to-back requests
  // keep it high across the accepting edge
  task automatic send_pixel(input logic signed [PIX_W-1:0] pix, input logic fof);
    int                gap;
    icv_pkg::pix_req_t req;
    gap = in_gaps_on ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.pixel          = pix;
    req.first_of_frame = fof;
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    board.predict_window_sum(req);
    items_sent++;
  endtask

  task automatic send_frame(input int count);
    int i;
    for (i = 0; i < count; i++) send_pixel(draw_pixel(), i == 0);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] mask;
    int         i, w_eff, h_eff, frame_len, style, random_start, cut;
    board = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first frame as wide as any later one so every line store column in
    // use is written; radius above range saturates here
    reg_val[icv_pkg::REG_KERNEL_RADIUS] = 3;
    reg_val[icv_pkg::REG_IMAGE_WIDTH]   = FIRST_W;
    reg_val[icv_pkg::REG_IMAGE_HEIGHT]  = 5;
    for (i = icv_pkg::REG_KERNEL_ROW0; i <= icv_pkg::REG_KERNEL_ROW4; i++)
      reg_val[i] = draw_kernel_row();
    program_regs(8'hff);
    send_frame(FIRST_W * 5);
    settle();

    // largest and smallest sums: most negative coefficient everywhere
    reg_val[icv_pkg::REG_KERNEL_RADIUS] = 1;
    reg_val[icv_pkg::REG_IMAGE_WIDTH]   = 3;
    reg_val[icv_pkg::REG_IMAGE_HEIGHT]  = 3;
    for (i = icv_pkg::REG_KERNEL_ROW0; i <= icv_pkg::REG_KERNEL_ROW4; i++)
      reg_val[i] = {5{12'h800}};
    program_regs(8'hff);
    for (i = 0; i < 9; i++) send_pixel(16'sh8000, i == 0);
    for (i = 0; i < 9; i++) send_pixel(16'sh7fff, i == 0);
    settle();

    // zero width and height act as one pixel; radius 0 emits every pixel
    reg_val[icv_pkg::REG_KERNEL_RADIUS] = 0;
    reg_val[icv_pkg::REG_IMAGE_WIDTH]   = 0;
    reg_val[icv_pkg::REG_IMAGE_HEIGHT]  = 0;
    program_regs(8'h07);
    send_pixel(16'sh8000, 1'b1);
    send_pixel(16'sh7fff, 1'b0);
    send_pixel(16'sh0000, 1'b0);
    settle();

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      mask = $urandom_range(1, 255);
      if (mask[icv_pkg::REG_KERNEL_RADIUS])
        reg_val[icv_pkg::REG_KERNEL_RADIUS] = $urandom_range(0, 3);
      if (mask[icv_pkg::REG_IMAGE_WIDTH]) begin
        case ($urandom_range(0, 9))
          0:       reg_val[icv_pkg::REG_IMAGE_WIDTH] = 0;
          1:       reg_val[icv_pkg::REG_IMAGE_WIDTH] = $urandom_range(1, 3);
          2:       reg_val[icv_pkg::REG_IMAGE_WIDTH] = $urandom_range(30, FIRST_W);
          default: reg_val[icv_pkg::REG_IMAGE_WIDTH] = $urandom_range(4, 16);
        endcase
      end
      if (mask[icv_pkg::REG_IMAGE_HEIGHT]) begin
        case ($urandom_range(0, 9))
          0:       reg_val[icv_pkg::REG_IMAGE_HEIGHT] = 0;
          1:       reg_val[icv_pkg::REG_IMAGE_HEIGHT] = $urandom_range(1024, 4095);
          default: reg_val[icv_pkg::REG_IMAGE_HEIGHT] = $urandom_range(1, 9);
        endcase
      end
      for (i = icv_pkg::REG_KERNEL_ROW0; i <= icv_pkg::REG_KERNEL_ROW4; i++)
        if (mask[i]) reg_val[i] = draw_kernel_row();
      program_regs(mask);

      in_gaps_on  = $urandom_range(0, 3) != 0;
      out_gaps_on = $urandom_range(0, 3) != 0;
      w_eff = (reg_val[icv_pkg::REG_IMAGE_WIDTH] == 0) ? 1 :
              ((reg_val[icv_pkg::REG_IMAGE_WIDTH] > MAX_W) ? MAX_W :
               int'(reg_val[icv_pkg::REG_IMAGE_WIDTH]));
      h_eff = (reg_val[icv_pkg::REG_IMAGE_HEIGHT] == 0) ? 1 :
              int'(reg_val[icv_pkg::REG_IMAGE_HEIGHT]);
      frame_len = w_eff * h_eff;
      style = (frame_len > 600) ? 9 : $urandom_range(0, 9);

      if (style <= 5) begin
        // whole frames, now and then cut short by an early restart
        repeat ($urandom_range(1, 3)) begin
          cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, frame_len) : frame_len;
          send_frame(cut);
        end
      end else if (style <= 7) begin
        // carry on from wherever the counters stand, then a clean frame
        repeat ($urandom_range(1, frame_len)) send_pixel(draw_pixel(), 1'b0);
        send_frame(frame_len);
      end else begin
        repeat ($urandom_range(20, 80)) send_pixel(draw_pixel(), $urandom_range(0, 15) == 0);
      end
      settle();
    end

    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/icv_pkg.sv
rtl/icv_fifo.sv
rtl/icv_front.sv
rtl/icv_back.sv
rtl/image_convolution_2d.sv
tb/sv/image_convolution_2d_tb.sv
